>>> rtl/psd_pkg.sv
// Shared constants and types for the point-to-segment distance pipeline.
package psd_pkg;

    localparam int COORD_WIDTH_DEF = 32;  // default coordinate width
    localparam int ROOT_BITS       = 32;  // bits of the distance result
    localparam int MUL_CHUNK       = 24;  // partial product chunk width
    localparam int MUL_LAT         = 3;   // multiplier latency in cycles

    // Control that travels alongside the data of one beat.
    typedef struct packed {
        logic valid;
        logic degen;
    } t_ctl;

endpackage

>>> rtl/psd_mul.sv
// Signed multiplier split into chunk partial products, three register stages.
module psd_mul #(
    parameter int AW = psd_pkg::COORD_WIDTH_DEF + 1
) (
    input  logic                   i_clk,
    input  logic signed [AW-1:0]   i_a,
    input  logic signed [AW-1:0]   i_b,
    output logic signed [2*AW-1:0] o_p
);

    localparam int CH = psd_pkg::MUL_CHUNK;
    localparam int N  = (AW + CH - 1) / CH;
    localparam int PW = N * CH;

    logic [AW-1:0]     r_ma;
    logic [AW-1:0]     r_mb;
    logic              r_neg_a;
    logic              r_neg_b;
    logic [PW-1:0]     ma_pad;
    logic [PW-1:0]     mb_pad;
    logic [2*CH-1:0]   r_pp [N*N];
    logic [2*PW-1:0]   acc;
    logic [2*PW-1:0]   n_p;
    logic signed [2*AW-1:0] r_p;

    // stage a: sign and magnitude
    always_ff @(posedge i_clk) begin
        r_ma    <= i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
        r_mb    <= i_b[AW-1] ? AW'(-i_b) : AW'(i_b);
        r_neg_a <= i_a[AW-1] ^ i_b[AW-1];
    end

    assign ma_pad = PW'(r_ma);
    assign mb_pad = PW'(r_mb);

    // stage b: chunk products
    always_ff @(posedge i_clk) begin
        r_neg_b <= r_neg_a;
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                r_pp[i*N+j] <= ma_pad[i*CH +: CH] * mb_pad[j*CH +: CH];
            end
        end
    end

    // stage c: weighted sum and sign
    always_comb begin
        acc = '0;
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                acc = acc + ((2*PW)'(r_pp[i*N+j]) << ((i + j) * CH));
            end
        end
        n_p = r_neg_b ? -acc : acc;
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p[2*AW-1:0];
    end

    assign o_p = r_p;

endmodule

>>> rtl/psd_root.sv
// Pipelined bit-per-stage floor(sqrt(num/den)), one result bit per stage.
module psd_root #(
    parameter int NUM_W = 4 * psd_pkg::COORD_WIDTH_DEF + 10,
    parameter int DEN_W = 2 * psd_pkg::COORD_WIDTH_DEF + 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  psd_pkg::t_ctl                i_ctl,
    input  logic [NUM_W-1:0]             i_num,
    input  logic [DEN_W-1:0]             i_den,
    output psd_pkg::t_ctl                o_ctl,
    output logic [psd_pkg::ROOT_BITS-1:0] o_root
);

    localparam int QB  = psd_pkg::ROOT_BITS;
    localparam int RW0 = (NUM_W > DEN_W + 2*QB + 2) ? NUM_W : DEN_W + 2*QB + 2;
    localparam int RW  = RW0 + 1;

    // s_* index k is the input of stage k; r_* index k is its output
    logic [RW-1:0]    s_rem [QB+1];
    logic [RW-1:0]    s_rd  [QB+1];
    logic [DEN_W-1:0] s_den [QB+1];
    logic [QB-1:0]    s_q   [QB+1];
    psd_pkg::t_ctl    s_ctl [QB+1];

    logic [RW-1:0]    r_rem [QB];
    logic [RW-1:0]    r_rd  [QB];
    logic [DEN_W-1:0] r_den [QB];
    logic [QB-1:0]    r_q   [QB];
    psd_pkg::t_ctl    r_ctl [QB];

    assign s_rem[0] = RW'(i_num);
    assign s_rd[0]  = '0;
    assign s_den[0] = i_den;
    assign s_q[0]   = '0;
    assign s_ctl[0] = i_ctl;

    for (genvar gi = 0; gi < QB; gi++) begin : g_stage
        localparam int B = QB - 1 - gi;
        logic [RW-1:0] trial;
        logic          ok;
        logic [RW-1:0] n_rem;
        logic [RW-1:0] n_rd;
        logic [QB-1:0] n_q;

        // (r + 2^B)^2 * den - r^2 * den = (2*r*den + den*2^B) * 2^B
        always_comb begin
            trial = ((s_rd[gi] << 1) + (RW'(s_den[gi]) << B)) << B;
            ok    = (trial <= s_rem[gi]);
            n_rem = ok ? s_rem[gi] - trial : s_rem[gi];
            n_rd  = ok ? s_rd[gi] + (RW'(s_den[gi]) << B) : s_rd[gi];
            n_q   = s_q[gi] | (QB'(ok) << B);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[gi] <= '0;
            end else begin
                r_ctl[gi] <= s_ctl[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[gi] <= n_rem;
            r_rd[gi]  <= n_rd;
            r_den[gi] <= s_den[gi];
            r_q[gi]   <= n_q;
        end

        assign s_rem[gi+1] = r_rem[gi];
        assign s_rd[gi+1]  = r_rd[gi];
        assign s_den[gi+1] = r_den[gi];
        assign s_q[gi+1]   = r_q[gi];
        assign s_ctl[gi+1] = r_ctl[gi];
    end

    assign o_ctl  = s_ctl[QB];
    assign o_root = s_q[QB];

endmodule

>>> rtl/point_segment_distance_3d.sv
// Top level: distance from a 3D query point to a segment, fully pipelined.
//
// Usage:
//  - Input channel: pulse start with the nine coordinates (A, B, P, signed
//    Q3.28 at COORD_WIDTH bits). A beat is taken at each edge with start high
//    and busy low. busy is always low: a new beat may enter every cycle.
//  - Result channel: o_valid is high for exactly one cycle with o_distance
//    (unsigned Q4.28, floor of the exact distance, saturating at all ones)
//    and o_degenerate (A equals B). The receiver cannot stall; results come
//    out in input order, one per accepted beat.
//  - Throughput: one beat per cycle. The pipeline is made of
//    1 difference stage, 3 squared/dot product multiplier stages, 1 sum
//    stage, 3 stages for |AP|^2*|AB|^2 and dot^2, 1 case select stage and
//    32 square root stages (one result bit each), in that order.
//  - Reset: synchronous, active low; clears the valid bits of every stage,
//    so beats in flight are dropped. Data registers are not reset.
//  - Inside the segment the squared distance is (|AP|^2*|AB|^2 - dot^2) /
//    |AB|^2, taken by the root stages as a ratio so no divider is needed.
module point_segment_distance_3d #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_z,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_y,
    input  logic signed [COORD_WIDTH-1:0] i_query_z,
    output logic                          o_valid,
    output logic [psd_pkg::ROOT_BITS-1:0] o_distance,
    output logic                          o_degenerate
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;        // coordinate differences
    localparam int PW  = 2 * DW;       // products of differences
    localparam int SW  = 2 * W + 4;    // sums of three products
    localparam int AW2 = SW + 1;       // second level operands
    localparam int NW  = 2 * AW2;      // second level products
    localparam int LAT = psd_pkg::MUL_LAT;

    // Never stalls: every stage advances each cycle.
    assign busy = 1'b0;

    logic signed [W-1:0] a_c [3];
    logic signed [W-1:0] b_c [3];
    logic signed [W-1:0] p_c [3];

    assign a_c[0] = i_seg_start_x;
    assign a_c[1] = i_seg_start_y;
    assign a_c[2] = i_seg_start_z;
    assign b_c[0] = i_seg_end_x;
    assign b_c[1] = i_seg_end_y;
    assign b_c[2] = i_seg_end_z;
    assign p_c[0] = i_query_x;
    assign p_c[1] = i_query_y;
    assign p_c[2] = i_query_z;

    // ---- stage 1: differences AB, AP, BP and the degenerate test
    psd_pkg::t_ctl        n1_ctl;
    psd_pkg::t_ctl        r1_ctl;
    logic signed [DW-1:0] r1_ab [3];
    logic signed [DW-1:0] r1_ap [3];
    logic signed [DW-1:0] r1_bp [3];

    always_comb begin
        n1_ctl.valid = start & ~busy;
        n1_ctl.degen = (a_c[0] == b_c[0]) && (a_c[1] == b_c[1]) && (a_c[2] == b_c[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= n1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_ab[k] <= DW'(b_c[k]) - DW'(a_c[k]);
            r1_ap[k] <= DW'(p_c[k]) - DW'(a_c[k]);
            r1_bp[k] <= DW'(p_c[k]) - DW'(b_c[k]);
        end
    end

    // ---- stages 2..4: twelve coordinate products
    logic signed [PW-1:0] m_abab [3];
    logic signed [PW-1:0] m_apab [3];
    logic signed [PW-1:0] m_apap [3];
    logic signed [PW-1:0] m_bpbp [3];

    for (genvar gk = 0; gk < 3; gk++) begin : g_prod
        psd_mul #(.AW(DW)) u_abab (.i_clk(i_clk), .i_a(r1_ab[gk]), .i_b(r1_ab[gk]),
                                   .o_p(m_abab[gk]));
        psd_mul #(.AW(DW)) u_apab (.i_clk(i_clk), .i_a(r1_ap[gk]), .i_b(r1_ab[gk]),
                                   .o_p(m_apab[gk]));
        psd_mul #(.AW(DW)) u_apap (.i_clk(i_clk), .i_a(r1_ap[gk]), .i_b(r1_ap[gk]),
                                   .o_p(m_apap[gk]));
        psd_mul #(.AW(DW)) u_bpbp (.i_clk(i_clk), .i_a(r1_bp[gk]), .i_b(r1_bp[gk]),
                                   .o_p(m_bpbp[gk]));
    end

    psd_pkg::t_ctl r2_ctl [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r2_ctl[i] <= '0;
            end
        end else begin
            r2_ctl[0] <= r1_ctl;
            for (int i = 1; i < LAT; i++) begin
                r2_ctl[i] <= r2_ctl[i-1];
            end
        end
    end

    // ---- stage 5: dot sums |AB|^2, AP.AB, |AP|^2, |BP|^2
    psd_pkg::t_ctl        r3_ctl;
    logic signed [SW-1:0] r3_len2;
    logic signed [SW-1:0] r3_dot;
    logic signed [SW-1:0] r3_ap2;
    logic signed [SW-1:0] r3_bp2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else begin
            r3_ctl <= r2_ctl[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r3_len2 <= SW'(m_abab[0]) + SW'(m_abab[1]) + SW'(m_abab[2]);
        r3_dot  <= SW'(m_apab[0]) + SW'(m_apab[1]) + SW'(m_apab[2]);
        r3_ap2  <= SW'(m_apap[0]) + SW'(m_apap[1]) + SW'(m_apap[2]);
        r3_bp2  <= SW'(m_bpbp[0]) + SW'(m_bpbp[1]) + SW'(m_bpbp[2]);
    end

    // ---- stages 6..8: |AP|^2*|AB|^2 and dot^2 (Lagrange identity)
    logic signed [AW2-1:0] l2_ap2;
    logic signed [AW2-1:0] l2_len2;
    logic signed [AW2-1:0] l2_dot;
    logic signed [NW-1:0]  m_full;
    logic signed [NW-1:0]  m_dotsq;

    assign l2_ap2  = {1'b0, r3_ap2};
    assign l2_len2 = {1'b0, r3_len2};
    assign l2_dot  = AW2'(r3_dot);

    psd_mul #(.AW(AW2)) u_full  (.i_clk(i_clk), .i_a(l2_ap2), .i_b(l2_len2),
                                 .o_p(m_full));
    psd_mul #(.AW(AW2)) u_dotsq (.i_clk(i_clk), .i_a(l2_dot), .i_b(l2_dot),
                                 .o_p(m_dotsq));

    psd_pkg::t_ctl        r4_ctl  [LAT];
    logic signed [SW-1:0] r4_len2 [LAT];
    logic signed [SW-1:0] r4_dot  [LAT];
    logic signed [SW-1:0] r4_ap2  [LAT];
    logic signed [SW-1:0] r4_bp2  [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r4_ctl[i] <= '0;
            end
        end else begin
            r4_ctl[0] <= r3_ctl;
            for (int i = 1; i < LAT; i++) begin
                r4_ctl[i] <= r4_ctl[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r4_len2[0] <= r3_len2;
        r4_dot[0]  <= r3_dot;
        r4_ap2[0]  <= r3_ap2;
        r4_bp2[0]  <= r3_bp2;
        for (int i = 1; i < LAT; i++) begin
            r4_len2[i] <= r4_len2[i-1];
            r4_dot[i]  <= r4_dot[i-1];
            r4_ap2[i]  <= r4_ap2[i-1];
            r4_bp2[i]  <= r4_bp2[i-1];
        end
    end

    // ---- stage 9: pick the case, form numerator and denominator
    psd_pkg::t_ctl        r5_ctl;
    logic [NW-1:0]        n5_num;
    logic [SW-1:0]        n5_den;
    logic [NW-1:0]        r5_num;
    logic [SW-1:0]        r5_den;
    logic signed [SW-1:0] s_len2;
    logic signed [SW-1:0] s_dot;
    logic signed [NW-1:0] cross2;

    assign s_len2 = r4_len2[LAT-1];
    assign s_dot  = r4_dot[LAT-1];
    assign cross2 = m_full - m_dotsq;

    always_comb begin
        priority if (r4_ctl[LAT-1].degen || s_dot[SW-1] || (s_dot == '0)) begin
            // projection at or before A, or A equals B
            n5_num = NW'(r4_ap2[LAT-1]);
            n5_den = SW'(1);
        end else if (s_dot >= s_len2) begin
            // projection at or beyond B
            n5_num = NW'(r4_bp2[LAT-1]);
            n5_den = SW'(1);
        end else begin
            n5_num = cross2;
            n5_den = s_len2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl <= '0;
        end else begin
            r5_ctl <= r4_ctl[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r5_num <= n5_num;
        r5_den <= n5_den;
    end

    // ---- stages 10..41: pipelined root of the ratio, one result bit per stage
    psd_pkg::t_ctl root_ctl;

    psd_root #(
        .NUM_W(NW),
        .DEN_W(SW)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r5_ctl),
        .i_num   (r5_num),
        .i_den   (r5_den),
        .o_ctl   (root_ctl),
        .o_root  (o_distance)
    );

    assign o_valid      = root_ctl.valid;
    assign o_degenerate = root_ctl.degen;

endmodule
